/* sv/rba_pkg.sv */
`default_nettype none
package rba_pkg;

  localparam int TableEntriesDefault = 64;
  localparam int PageShiftDefault    = 12;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_ALLOC  = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [1:0] REG_LOW_LIMIT  = 2'd0;
  localparam logic [1:0] REG_HIGH_LIMIT = 2'd1;
  localparam logic [1:0] REG_AVAIL_KIND = 2'd2;
  localparam logic [1:0] REG_CLAIM_KIND = 2'd3;

  localparam logic [31:0] LowLimitReset  = 32'h0010_0000;
  localparam logic [31:0] HighLimitReset = 32'hFFFF_FFFF;
  localparam logic [3:0]  AvailKindReset = 4'd1;
  localparam logic [3:0]  ClaimKindReset = 4'd7;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [3:0]  kind;
  } entry_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_APPEND,
    CMD_RD_IDX,
    CMD_RD_ACT,
    CMD_CAP_READ,
    CMD_BUMP,
    CMD_CLAIM,
    CMD_SCAN_START,
    CMD_SCAN_STEP,
    CMD_SCAN_COMMIT,
    CMD_SPLIT_START,
    CMD_SHIFT,
    CMD_SPLIT_HI,
    CMD_SPLIT_LO,
    CMD_LOAD_OUT
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       set_status;
    logic [1:0] status_code;
  } ctl_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       active_ok;
    logic       idx_ok;
    logic       fits;
    logic       total_zero;
    logic       scan_last;
    logic       found;
    logic       shift_none;
    logic       shift_last;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

/* sv/region_bump_allocator_unit.sv */
// Region bump allocator: a table of memory regions with a bump pointer.
// Input channel (in_valid/in_ready) carries one operation per transaction:
// append entry, allocate, update map (split the current region) or read entry.
// Output channel (out_valid/out_ready) returns exactly one result per operation.
// Configuration: write_enable/register_index/write_data, taken every cycle it is
// high; write only while no operation is in flight.
// Steps per transaction, from accept to result valid:
//   append or refused operation: goes straight to the result; read: waits on
//   the registered table read; allocate that fits the current region: reads it
//   and bumps the offset; allocate or update needing a new region: scans the
//   table, one entry per cycle through the single memory read port;
//   update map split: moves the entries after the current one one slot up,
//   one per cycle, then writes the two halves.
// One operation is worked at a time; a new one is accepted while the previous
// result still waits in the output register.
// Reset clears the entry count, drops the current region, zeroes the offset
// and restores the limit and kind registers; table contents are not cleared.
// When the receiver stalls, hold the result; the block finishes the next
// operation and then waits before loading its result.
`default_nettype none
module region_bump_allocator_unit #(
  parameter int TABLE_ENTRIES = rba_pkg::TableEntriesDefault,
  parameter int PAGE_SHIFT    = rba_pkg::PageShiftDefault
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                write_enable,
  input  wire  [1:0]         register_index,
  input  wire  [31:0]        write_data,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [1:0]         operation,
  input  wire  [5:0]         entry_index,
  input  wire  [63:0]        entry_base,
  input  wire  [63:0]        entry_length,
  input  wire  [3:0]         entry_kind,
  input  wire  [31:0]        request_size,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [1:0]         status,
  output logic [63:0]        address,
  output logic [63:0]        read_base,
  output logic [63:0]        read_length,
  output logic [3:0]         read_kind,
  output logic [6:0]         entries_used,
  output logic signed [6:0]  current_region
);

  // command from the sequencer, status back from the datapath
  rba_pkg::ctl_t ctl;
  rba_pkg::sts_t sts;

  rba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  rba_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PAGE_SHIFT    (PAGE_SHIFT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .operation      (operation),
    .entry_index    (entry_index),
    .entry_base     (entry_base),
    .entry_length   (entry_length),
    .entry_kind     (entry_kind),
    .request_size   (request_size),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .address        (address),
    .read_base      (read_base),
    .read_length    (read_length),
    .read_kind      (read_kind),
    .entries_used   (entries_used),
    .current_region (current_region)
  );

endmodule
`default_nettype wire

/* sv/rba_ctrl.sv */
`default_nettype none
module rba_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  rba_pkg::sts_t    sts,
  output rba_pkg::ctl_t    ctl
);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_DISP    = 13'b0000000000010,
    S_RDWAIT  = 13'b0000000000100,
    S_FIT     = 13'b0000000001000,
    S_SCAN0   = 13'b0000000010000,
    S_SCAN    = 13'b0000000100000,
    S_SCANEND = 13'b0000001000000,
    S_SPLITRD = 13'b0000010000000,
    S_SHIFT   = 13'b0000100000000,
    S_SPLITHI = 13'b0001000000000,
    S_SPLITLO = 13'b0010000000000,
    S_DONE    = 13'b0100000000000,
    S_SPARE   = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '{cmd: rba_pkg::CMD_NONE, set_status: 1'b0, status_code: rba_pkg::ST_OK};
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.cmd = rba_pkg::CMD_LATCH;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          rba_pkg::OP_APPEND: begin
            if (sts.full) begin
              ctl.set_status = 1'b1;
              ctl.status_code = rba_pkg::ST_FULL;
            end else begin
              ctl.cmd = rba_pkg::CMD_APPEND;
            end
            state_next = S_DONE;
          end
          rba_pkg::OP_READ: begin
            if (!sts.idx_ok) begin
              ctl.set_status = 1'b1;
              ctl.status_code = rba_pkg::ST_RANGE;
              state_next = S_DONE;
            end else begin
              ctl.cmd = rba_pkg::CMD_RD_IDX;
              state_next = S_RDWAIT;
            end
          end
          rba_pkg::OP_ALLOC: begin
            if (sts.active_ok) begin
              ctl.cmd = rba_pkg::CMD_RD_ACT;
              state_next = S_FIT;
            end else begin
              state_next = S_SCAN0;
            end
          end
          default: begin
            if (!sts.active_ok) begin
              state_next = S_SCAN0;
            end else if (sts.full) begin
              ctl.set_status = 1'b1;
              ctl.status_code = rba_pkg::ST_FULL;
              state_next = S_DONE;
            end else begin
              ctl.cmd = rba_pkg::CMD_RD_ACT;
              state_next = S_SPLITRD;
            end
          end
        endcase
      end
      S_RDWAIT: begin
        ctl.cmd = rba_pkg::CMD_CAP_READ;
        state_next = S_DONE;
      end
      S_FIT: begin
        if (sts.fits) begin
          ctl.cmd = rba_pkg::CMD_BUMP;
          state_next = S_DONE;
        end else begin
          ctl.cmd = rba_pkg::CMD_CLAIM;
          state_next = S_SCAN0;
        end
      end
      S_SCAN0: begin
        ctl.cmd = rba_pkg::CMD_SCAN_START;
        state_next = sts.total_zero ? S_SCANEND : S_SCAN;
      end
      S_SCAN: begin
        ctl.cmd = rba_pkg::CMD_SCAN_STEP;
        if (sts.scan_last) begin
          state_next = S_SCANEND;
        end
      end
      S_SCANEND: begin
        if (sts.found) begin
          ctl.cmd = rba_pkg::CMD_SCAN_COMMIT;
        end else begin
          ctl.set_status = 1'b1;
          ctl.status_code = rba_pkg::ST_NONE;
        end
        state_next = S_DONE;
      end
      S_SPLITRD: begin
        ctl.cmd = rba_pkg::CMD_SPLIT_START;
        state_next = sts.shift_none ? S_SPLITHI : S_SHIFT;
      end
      S_SHIFT: begin
        ctl.cmd = rba_pkg::CMD_SHIFT;
        if (sts.shift_last) begin
          state_next = S_SPLITHI;
        end
      end
      S_SPLITHI: begin
        ctl.cmd = rba_pkg::CMD_SPLIT_HI;
        state_next = S_SPLITLO;
      end
      S_SPLITLO: begin
        ctl.cmd = rba_pkg::CMD_SPLIT_LO;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.cmd = rba_pkg::CMD_LOAD_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/rba_datapath.sv */
`default_nettype none
module rba_datapath #(
  parameter int TABLE_ENTRIES = rba_pkg::TableEntriesDefault,
  parameter int PAGE_SHIFT    = rba_pkg::PageShiftDefault
) (
  input  wire                 clk,
  input  wire                 rst,
  input  rba_pkg::ctl_t       ctl,
  output rba_pkg::sts_t       sts,
  input  wire                 write_enable,
  input  wire  [1:0]          register_index,
  input  wire  [31:0]         write_data,
  input  wire  [1:0]          operation,
  input  wire  [5:0]          entry_index,
  input  wire  [63:0]         entry_base,
  input  wire  [63:0]         entry_length,
  input  wire  [3:0]          entry_kind,
  input  wire  [31:0]         request_size,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [1:0]          status,
  output logic [63:0]         address,
  output logic [63:0]         read_base,
  output logic [63:0]         read_length,
  output logic [3:0]          read_kind,
  output logic [6:0]          entries_used,
  output logic signed [6:0]   current_region
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [32:0] PageMask = (33'(1) << PAGE_SHIFT) - 33'(1);

  rba_pkg::entry_t mem [TABLE_ENTRIES];
  rba_pkg::entry_t rd;
  logic [IW-1:0]   rd_addr;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  rba_pkg::entry_t wr_data;

  logic [31:0] low_limit, high_limit;
  logic [3:0]  available_kind, claimed_kind;

  logic [CW-1:0] total;
  logic          active_vld;
  logic [IW-1:0] active_idx;
  logic [63:0]   bump_offset;

  logic [1:0]  lat_op;
  logic [5:0]  lat_idx;
  logic [63:0] lat_base, lat_length;
  logic [3:0]  lat_kind;
  logic [32:0] lat_size;

  logic [CW-1:0] rptr, wptr;
  logic          found;
  logic [IW-1:0] best_idx;
  logic [63:0]   best_len, best_base;
  logic [63:0]   cur_base, cur_len;
  logic [3:0]    cur_kind;

  logic [1:0]  res_status;
  logic [63:0] res_addr, res_rb, res_rl;
  logic [3:0]  res_rk;

  logic        out_free;
  logic        cand, better;
  logic [63:0] room;

  // table memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd <= mem[rd_addr];
  end

  always_comb begin
    rd_addr = '0;
    case (ctl.cmd)
      rba_pkg::CMD_RD_IDX:      rd_addr = IW'(lat_idx);
      rba_pkg::CMD_RD_ACT:      rd_addr = active_idx;
      rba_pkg::CMD_SCAN_STEP:   rd_addr = rptr[IW-1:0];
      rba_pkg::CMD_SPLIT_START: rd_addr = IW'(total - CW'(1));
      rba_pkg::CMD_SHIFT:       rd_addr = IW'(wptr - CW'(2));
      default:                  rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en = 1'b1;
    wr_addr = active_idx;
    wr_data = rd;
    case (ctl.cmd)
      rba_pkg::CMD_APPEND: begin
        wr_addr = total[IW-1:0];
        wr_data = '{base: lat_base, length: lat_length, kind: lat_kind};
      end
      rba_pkg::CMD_CLAIM: begin
        wr_data = '{base: rd.base, length: rd.length, kind: claimed_kind};
      end
      rba_pkg::CMD_SHIFT: begin
        wr_addr = wptr[IW-1:0];
      end
      rba_pkg::CMD_SPLIT_HI: begin
        wr_addr = active_idx + IW'(1);
        wr_data = '{base: cur_base + bump_offset,
                    length: (bump_offset <= cur_len) ? cur_len - bump_offset : 64'd0,
                    kind: cur_kind};
      end
      rba_pkg::CMD_SPLIT_LO: begin
        wr_data = '{base: cur_base, length: bump_offset, kind: claimed_kind};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // scan candidate test on the entry returned this cycle
  assign cand = (rd.kind == available_kind) && (rd.base >= {32'd0, low_limit})
                && (rd.base < {32'd0, high_limit});
  assign better = !found || (best_len < rd.length);
  assign room = rd.length - bump_offset;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    sts.op = lat_op;
    sts.full = (total == CW'(TABLE_ENTRIES));
    sts.active_ok = active_vld;
    sts.idx_ok = (32'(lat_idx) < 32'(total));
    sts.fits = (bump_offset <= rd.length) && ({31'd0, lat_size} <= room);
    sts.total_zero = (total == '0);
    sts.scan_last = (rptr == total);
    sts.found = found;
    sts.shift_none = ((CW+1)'(active_idx) + (CW+1)'(1) == (CW+1)'(total));
    sts.shift_last = ((CW+1)'(wptr) == (CW+1)'(active_idx) + (CW+1)'(2));
    sts.out_free = out_free;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit <= rba_pkg::LowLimitReset;
      high_limit <= rba_pkg::HighLimitReset;
      available_kind <= rba_pkg::AvailKindReset;
      claimed_kind <= rba_pkg::ClaimKindReset;
    end else if (write_enable) begin
      case (register_index)
        rba_pkg::REG_LOW_LIMIT:  low_limit <= write_data;
        rba_pkg::REG_HIGH_LIMIT: high_limit <= write_data;
        rba_pkg::REG_AVAIL_KIND: available_kind <= write_data[3:0];
        default:                 claimed_kind <= write_data[3:0];
      endcase
    end
  end

  // allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      active_vld <= 1'b0;
      active_idx <= '0;
      bump_offset <= '0;
    end else begin
      case (ctl.cmd)
        rba_pkg::CMD_APPEND: total <= total + CW'(1);
        rba_pkg::CMD_SPLIT_LO: total <= total + CW'(1);
        rba_pkg::CMD_BUMP: bump_offset <= bump_offset + 64'(lat_size);
        rba_pkg::CMD_SCAN_COMMIT: begin
          active_vld <= 1'b1;
          active_idx <= best_idx;
          bump_offset <= (lat_op == rba_pkg::OP_ALLOC) ? 64'(lat_size) : 64'd0;
        end
        default: ;
      endcase
    end
  end

  // transaction latch, scan, split and result registers
  always_ff @(posedge clk) begin
    if (ctl.set_status) begin
      res_status <= ctl.status_code;
    end
    case (ctl.cmd)
      rba_pkg::CMD_LATCH: begin
        lat_op <= operation;
        lat_idx <= entry_index;
        lat_base <= entry_base;
        lat_length <= entry_length;
        lat_kind <= entry_kind;
        lat_size <= ({1'b0, request_size} + PageMask) & ~PageMask;
        res_status <= rba_pkg::ST_OK;
        res_addr <= '0;
        res_rb <= '0;
        res_rl <= '0;
        res_rk <= '0;
      end
      rba_pkg::CMD_CAP_READ: begin
        res_rb <= rd.base;
        res_rl <= rd.length;
        res_rk <= rd.kind;
      end
      rba_pkg::CMD_BUMP: res_addr <= rd.base + bump_offset;
      rba_pkg::CMD_SCAN_START: begin
        rptr <= CW'(1);
        found <= 1'b0;
      end
      rba_pkg::CMD_SCAN_STEP: begin
        rptr <= rptr + CW'(1);
        if (cand && better) begin
          found <= 1'b1;
          best_idx <= IW'(rptr - CW'(1));
          best_len <= rd.length;
          best_base <= rd.base;
        end
      end
      rba_pkg::CMD_SCAN_COMMIT: begin
        if (lat_op == rba_pkg::OP_ALLOC) begin
          res_addr <= best_base;
        end
      end
      rba_pkg::CMD_SPLIT_START: begin
        cur_base <= rd.base;
        cur_len <= rd.length;
        cur_kind <= rd.kind;
        wptr <= total;
      end
      rba_pkg::CMD_SHIFT: wptr <= wptr - CW'(1);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.cmd == rba_pkg::CMD_LOAD_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == rba_pkg::CMD_LOAD_OUT) begin
      status <= res_status;
      address <= res_addr;
      read_base <= res_rb;
      read_length <= res_rl;
      read_kind <= res_rk;
      entries_used <= 7'(total);
      current_region <= active_vld ? 7'(active_idx) : 7'h7F;
    end
  end

  a_active_in_table: assert property (@(posedge clk) disable iff (rst)
    active_vld |-> (CW'(active_idx) < total))
    else $error("current region outside table");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(TABLE_ENTRIES))
    else $error("entry count above table size");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.cmd == rba_pkg::CMD_LOAD_OUT) |-> out_free)
    else $error("result loaded over an untaken result");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    (ctl.cmd == rba_pkg::CMD_APPEND) |=> (total == $past(total) + CW'(1)))
    else $error("append did not advance entry count");

endmodule
`default_nettype wire
